// ----- rtl/crcfr_pkg.sv -----
// crcfr_pkg: shared types, constants and the crc-32 byte update
// for the checked frame receiver; no dependencies

package crcfr_pkg;

    typedef logic [1:0]  status_t;
    typedef logic [31:0] word_t;

    localparam status_t StatusProgress = 2'd0;
    localparam status_t StatusOk       = 2'd1;
    localparam status_t StatusBadMagic = 2'd2;
    localparam status_t StatusBadCrc   = 2'd3;

    localparam word_t      MagicReset = 32'h1234_4321;
    localparam word_t      CrcPoly    = 32'hEDB8_8320;
    localparam word_t      CrcInit    = 32'hFFFF_FFFF;
    localparam logic [3:0] HeaderLast = 4'd11;

    // reflected crc-32, one byte, unrolled xor network
    function automatic word_t crc_byte(input word_t crc_in, input logic [7:0] data);
        word_t c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CrcPoly;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ----- rtl/crc32_checked_frame_receiver.sv -----
// crc32_checked_frame_receiver: length-prefixed frame deframer with crc-32 check
// depends on crcfr_pkg
// each result is registered: it appears in the output register in the cycle after its input transfer
// throughput: one byte per cycle while in_stall is low; the crc byte update is a combinational xor network
// in_stall rises only while a held result is stalled at the output
// reset (rst_n low, asynchronous): header phase, counters cleared, crc all ones,
// frame_magic back to 0x12344321, output register empty

module crc32_checked_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  payload_byte,
    output logic        has_data,
    output logic        frame_end,
    output logic [1:0]  status
);

    logic [31:0] frame_magic_reg;
    logic        in_payload_reg,    in_payload_next;
    logic [3:0]  header_index_reg,  header_index_next;
    logic [31:0] magic_seen_reg,    magic_seen_next;
    logic [31:0] length_seen_reg,   length_seen_next;
    logic [31:0] checksum_seen_reg, checksum_seen_next;
    logic [31:0] running_crc_reg,   running_crc_next;
    logic [31:0] bytes_left_reg,    bytes_left_next;

    logic        out_valid_reg,     out_valid_next;
    logic [7:0]  payload_byte_reg,  payload_byte_next;
    logic        has_data_reg,      has_data_next;
    logic        frame_end_reg,     frame_end_next;
    crcfr_pkg::status_t status_reg, status_next;

    logic        accept;
    logic        res_valid;
    logic [31:0] crc_step;
    logic [3:0]  hdr_idx;
    logic [4:0]  hdr_shift;

    assign cfg_ready    = 1'b1;
    assign in_stall     = out_valid_reg & out_stall;
    assign accept       = in_valid & ~in_stall;
    assign out_valid    = out_valid_reg;
    assign payload_byte = payload_byte_reg;
    assign has_data     = has_data_reg;
    assign frame_end    = frame_end_reg;
    assign status       = status_reg;

    assign crc_step  = crcfr_pkg::crc_byte(running_crc_reg, data_byte);
    assign hdr_idx   = (header_index_reg > crcfr_pkg::HeaderLast) ?
                       crcfr_pkg::HeaderLast : header_index_reg;
    assign hdr_shift = {hdr_idx[1:0], 3'b000};

    always_comb
    begin
        in_payload_next    = in_payload_reg;
        header_index_next  = header_index_reg;
        magic_seen_next    = magic_seen_reg;
        length_seen_next   = length_seen_reg;
        checksum_seen_next = checksum_seen_reg;
        running_crc_next   = running_crc_reg;
        bytes_left_next    = bytes_left_reg;
        res_valid          = 1'b0;
        payload_byte_next  = 8'd0;
        has_data_next      = 1'b0;
        frame_end_next     = 1'b0;
        status_next        = crcfr_pkg::StatusProgress;

        if (accept)
        begin
            if (in_payload_reg)
            begin
                running_crc_next  = crc_step;
                bytes_left_next   = bytes_left_reg - 32'd1;
                res_valid         = 1'b1;
                payload_byte_next = data_byte;
                has_data_next     = 1'b1;
                if (bytes_left_reg == 32'd1)
                begin
                    in_payload_next   = 1'b0;
                    header_index_next = 4'd0;
                    frame_end_next    = 1'b1;
                    status_next       = ((~crc_step) == checksum_seen_reg) ?
                                        crcfr_pkg::StatusOk : crcfr_pkg::StatusBadCrc;
                end
            end
            else
            begin
                case (hdr_idx[3:2])
                    2'd0:    magic_seen_next[hdr_shift +: 8]    = data_byte;
                    2'd1:    length_seen_next[hdr_shift +: 8]   = data_byte;
                    default: checksum_seen_next[hdr_shift +: 8] = data_byte;
                endcase

                if (hdr_idx != crcfr_pkg::HeaderLast)
                begin
                    header_index_next = hdr_idx + 4'd1;
                end
                else
                begin
                    header_index_next = 4'd0;
                    if (magic_seen_reg != frame_magic_reg)
                    begin
                        res_valid      = 1'b1;
                        frame_end_next = 1'b1;
                        status_next    = crcfr_pkg::StatusBadMagic;
                    end
                    else if (length_seen_reg == 32'd0)
                    begin
                        res_valid      = 1'b1;
                        frame_end_next = 1'b1;
                        status_next    = (checksum_seen_next == 32'd0) ?
                                         crcfr_pkg::StatusOk : crcfr_pkg::StatusBadCrc;
                    end
                    else
                    begin
                        in_payload_next  = 1'b1;
                        bytes_left_next  = length_seen_reg;
                        running_crc_next = crcfr_pkg::CrcInit;
                    end
                end
            end
        end

        // result register: load on a new result, drain on an output transfer
        if (res_valid)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_magic_reg   <= crcfr_pkg::MagicReset;
            in_payload_reg    <= 1'b0;
            header_index_reg  <= 4'd0;
            magic_seen_reg    <= 32'd0;
            length_seen_reg   <= 32'd0;
            checksum_seen_reg <= 32'd0;
            running_crc_reg   <= crcfr_pkg::CrcInit;
            bytes_left_reg    <= 32'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                frame_magic_reg <= cfg_data;
            in_payload_reg    <= in_payload_next;
            header_index_reg  <= header_index_next;
            magic_seen_reg    <= magic_seen_next;
            length_seen_reg   <= length_seen_next;
            checksum_seen_reg <= checksum_seen_next;
            running_crc_reg   <= running_crc_next;
            bytes_left_reg    <= bytes_left_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            payload_byte_reg <= payload_byte_next;
            has_data_reg     <= has_data_next;
            frame_end_reg    <= frame_end_next;
            status_reg       <= status_next;
        end
    end

`ifndef ASSERT_OFF
    a_payload_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (bytes_left_reg != 32'd0))
        else $error("payload phase with no bytes left");

    a_header_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        !in_payload_reg |-> (header_index_reg <= crcfr_pkg::HeaderLast))
        else $error("header index out of range");

    a_open_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !frame_end_reg) |->
            (has_data_reg && status_reg == crcfr_pkg::StatusProgress))
        else $error("mid-frame result without payload byte");

    a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !has_data_reg) |->
            (payload_byte_reg == 8'd0 && frame_end_reg))
        else $error("result without data is not a zero frame end");
`endif

endmodule

// ----- bench/tb_crc32_checked_frame_receiver.sv -----
// tb_crc32_checked_frame_receiver: self-checking bench for the crc-32 checked frame receiver
// queued byte stream driver, stall-driven monitor and a byte-level deframer predictor
// depends on crcfr_pkg and crc32_checked_frame_receiver

module tb_crc32_checked_frame_receiver;

    localparam int CycleLimit = 400000;
    localparam int HoldCycles = 80;
    localparam int PhaseBytes = 305;
    localparam int MaxReports = 150;

    typedef struct packed {
        logic [7:0]         payload_byte;
        logic               has_data;
        logic               frame_end;
        crcfr_pkg::status_t status;
    } rx_result_t;

    typedef enum int {
        KindNoise,
        KindBadMagic,
        KindEmpty,
        KindBadCrc,
        KindGood
    } frame_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  payload_byte;
    logic        has_data;
    logic        frame_end;
    crcfr_pkg::status_t status;

    logic [7:0]  byte_queue[$];
    logic [7:0]  frame_buf[$];
    rx_result_t  expected_results[$];

    // predictor state
    crcfr_pkg::word_t model_magic = crcfr_pkg::MagicReset;
    logic             rx_in_payload = 1'b0;
    logic [3:0]       rx_hdr_pos = '0;
    crcfr_pkg::word_t rx_magic = '0;
    crcfr_pkg::word_t rx_length = '0;
    crcfr_pkg::word_t rx_checksum = '0;
    crcfr_pkg::word_t rx_crc = crcfr_pkg::CrcInit;
    crcfr_pkg::word_t rx_left = '0;

    logic        no_idle = 1'b0;
    int          hold_requests = 0;
    int          holds_served = 0;
    int          hold_left = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    crc32_checked_frame_receiver u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .has_data     (has_data),
        .frame_end    (frame_end),
        .status       (status)
    );

    always #10 clk = ~clk;

    // lsb-first serial form of the reflected crc-32
    function automatic crcfr_pkg::word_t crc32_step(input crcfr_pkg::word_t crc,
                                                    input logic [7:0] b);
        crcfr_pkg::word_t c;
        logic             fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = {1'b0, c[31:1]} ^ (fb ? crcfr_pkg::CrcPoly : 32'd0);
        end
        return c;
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        rx_result_t r;
        logic [3:0] pos;
        r = '0;
        if (rx_in_payload)
        begin
            rx_crc = crc32_step(rx_crc, b);
            rx_left = rx_left - 32'd1;
            r.payload_byte = b;
            r.has_data = 1'b1;
            r.status = crcfr_pkg::StatusProgress;
            if (rx_left == 0)
            begin
                rx_in_payload = 1'b0;
                rx_hdr_pos = '0;
                r.frame_end = 1'b1;
                r.status = ((~rx_crc) == rx_checksum) ?
                           crcfr_pkg::StatusOk : crcfr_pkg::StatusBadCrc;
            end
            expected_results.push_back(r);
        end
        else
        begin
            pos = (rx_hdr_pos > crcfr_pkg::HeaderLast) ? crcfr_pkg::HeaderLast : rx_hdr_pos;
            case (pos[3:2])
                2'd0:    rx_magic[{pos[1:0], 3'b000} +: 8] = b;
                2'd1:    rx_length[{pos[1:0], 3'b000} +: 8] = b;
                default: rx_checksum[{pos[1:0], 3'b000} +: 8] = b;
            endcase
            if (pos < crcfr_pkg::HeaderLast)
                rx_hdr_pos = pos + 4'd1;
            else
            begin
                rx_hdr_pos = '0;
                r.frame_end = 1'b1;
                if (rx_magic != model_magic)
                begin
                    r.status = crcfr_pkg::StatusBadMagic;
                    expected_results.push_back(r);
                end
                else if (rx_length == 0)
                begin
                    r.status = (rx_checksum == 0) ?
                               crcfr_pkg::StatusOk : crcfr_pkg::StatusBadCrc;
                    expected_results.push_back(r);
                end
                else
                begin
                    rx_in_payload = 1'b1;
                    rx_left = rx_length;
                    rx_crc = crcfr_pkg::CrcInit;
                end
            end
        end
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (mismatch_count < MaxReports)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatch_count++;
    endtask

    // byte transfer driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                deframe_byte(data_byte);
            if (!in_valid || !in_stall)
            begin
                if (byte_queue.size() != 0 && (no_idle || $urandom_range(99) >= 17))
                begin
                    in_valid  <= 1'b1;
                    data_byte <= byte_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and output stall
    always @(posedge clk)
    begin
        rx_result_t r;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatch_count < MaxReports)
                        $display("%0t: unexpected result, expected none, actual %h %b %b %0d",
                                 $time, payload_byte, has_data, frame_end, status);
                    mismatch_count++;
                end
                else
                begin
                    r = expected_results.pop_front();
                    if (payload_byte !== r.payload_byte)
                        report_field("payload_byte", 32'(r.payload_byte), 32'(payload_byte));
                    if (has_data !== r.has_data)
                        report_field("has_data", 32'(r.has_data), 32'(has_data));
                    if (frame_end !== r.frame_end)
                        report_field("frame_end", 32'(r.frame_end), 32'(frame_end));
                    if (status !== r.status)
                        report_field("status", 32'(r.status), 32'(status));
                end
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (holds_served != hold_requests)
            begin
                out_stall    <= 1'b1;
                holds_served <= holds_served + 1;
                hold_left    <= HoldCycles;
            end
            else
                out_stall <= !no_idle && ($urandom_range(99) < 17);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic wait_idle();
        do
            @(posedge clk);
        while (byte_queue.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_magic(input crcfr_pkg::word_t value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model_magic = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic put_header(input crcfr_pkg::word_t magic, input crcfr_pkg::word_t len,
                              input crcfr_pkg::word_t chk);
        for (int k = 0; k < 4; k++)
            frame_buf.push_back(magic[8*k +: 8]);
        for (int k = 0; k < 4; k++)
            frame_buf.push_back(len[8*k +: 8]);
        for (int k = 0; k < 4; k++)
            frame_buf.push_back(chk[8*k +: 8]);
    endtask

    task automatic build_frame(input crcfr_pkg::word_t magic, input int unsigned len,
                               input bit bad_crc);
        crcfr_pkg::word_t crc;
        logic [7:0]       body[$];
        crc = crcfr_pkg::CrcInit;
        for (int i = 0; i < len; i++)
        begin
            body.push_back(8'($urandom_range(255)));
            crc = crc32_step(crc, body[i]);
        end
        crc = ~crc;
        if (bad_crc)
            crc ^= 32'd1 << $urandom_range(31);
        put_header(magic, len, crc);
        foreach (body[i])
            frame_buf.push_back(body[i]);
    endtask

    task automatic send_frame_buf(input int from, input int upto);
        for (int i = from; i < upto; i++)
            byte_queue.push_back(frame_buf[i]);
    endtask

    function automatic int unsigned pick_length();
        int unsigned lr;
        lr = $urandom_range(99);
        if (lr < 70)
            return $urandom_range(8, 1);
        else if (lr < 95)
            return $urandom_range(40, 9);
        return $urandom_range(300, 41);
    endfunction

    task automatic queue_random_frame(inout int sent);
        int          r;
        frame_kind_t kind;
        frame_buf.delete();
        r = $urandom_range(99);
        kind = (r < 8)  ? KindNoise    :
               (r < 16) ? KindBadMagic :
               (r < 26) ? KindEmpty    :
               (r < 42) ? KindBadCrc   : KindGood;
        case (kind)
            KindNoise:
            begin
                frame_buf.push_back(model_magic[7:0] ^ 8'($urandom_range(255, 1)));
                repeat (11) frame_buf.push_back(8'($urandom_range(255)));
            end
            KindBadMagic:
                put_header(model_magic ^ (32'd1 << $urandom_range(31)), $urandom, $urandom);
            KindEmpty:
                build_frame(model_magic, 0, 1'($urandom_range(1)));
            KindBadCrc:
                build_frame(model_magic, pick_length(), 1'b1);
            default:
                build_frame(model_magic, pick_length(), 1'b0);
        endcase
        send_frame_buf(0, frame_buf.size());
        sent += frame_buf.size();
    endtask

    initial
    begin
        int               sent;
        crcfr_pkg::word_t next_magic;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // bad magic with every header byte all ones, then a one-byte frame of zero
        frame_buf.delete();
        put_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_header(crcfr_pkg::MagicReset, 32'd1, ~crc32_step(crcfr_pkg::CrcInit, 8'h00));
        frame_buf.push_back(8'h00);
        send_frame_buf(0, frame_buf.size());

        for (int phase = 0; phase < 5; phase++)
        begin
            sent = 0;
            case (phase)
                1: write_magic(32'h0000_0000);
                2: write_magic(32'hFFFF_FFFF);
                3:
                begin
                    // magic changes while a header is half received
                    next_magic = $urandom;
                    frame_buf.delete();
                    build_frame(next_magic, pick_length(), 1'b0);
                    send_frame_buf(0, 6);
                    wait_idle();
                    write_magic(next_magic);
                    send_frame_buf(6, frame_buf.size());
                    sent = frame_buf.size();
                end
                4: write_magic(crcfr_pkg::MagicReset);
                default: ;
            endcase
            no_idle = (phase == 2);
            while (sent < PhaseBytes)
                queue_random_frame(sent);
            if (phase == 1)
                hold_requests++;
            wait_idle();
        end
        no_idle = 1'b0;

        wait_idle();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
